### rtl/sfe_pkg.sv
// Shared types, line codes and the FCS-16 byte update for the SLIP framer.
// No dependencies; used by sfe_burst_out, slip_frame_encoder_fcs16_top, the checker and the testbench.
package sfe_pkg;

  // SLIP line codes
  localparam logic [7:0] LINE_END     = 8'hC0;
  localparam logic [7:0] LINE_ESC     = 8'hDB;
  localparam logic [7:0] LINE_ESC_END = 8'hDC;
  localparam logic [7:0] LINE_ESC_ESC = 8'hDD;

  // PPP FCS-16, reflected polynomial
  localparam logic [15:0] FCS_INIT = 16'hFFFF;
  localparam logic [15:0] FCS_POLY = 16'h8408;

  localparam logic [7:0] CHECKED_TYPE_RST = 8'hA9;

  // Item kinds on the input tuser
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam int unsigned BURST_MAX = 3;

  // Line bytes caused by one item, sent from bytes[0] up
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [1:0]                count;
  } burst_t;

  function automatic logic [15:0] fcs_byte(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] v;
    v = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ FCS_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

### rtl/sfe_burst_out.sv
// Output burst register: holds the line bytes of one item and sends them one per cycle while m_axis_tready is high.
// Depends on sfe_pkg (burst_t).
module sfe_burst_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sfe_pkg::burst_t burst_i,
  output logic            space_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // line_byte
  output logic            m_axis_tlast    // last_of_run
);

  logic [sfe_pkg::BURST_MAX-1:0][7:0] byte_q, byte_d;
  logic [1:0] left_q, left_d;
  logic       fire;

  assign fire    = m_axis_tvalid && m_axis_tready;
  // Room for the next item once the final byte of this one leaves
  assign space_o = (left_q == 2'd0) || ((left_q == 2'd1) && m_axis_tready);

  assign m_axis_tvalid = (left_q != 2'd0);
  assign m_axis_tdata  = byte_q[0];
  assign m_axis_tlast  = (left_q == 2'd1);

  always_comb begin
    byte_d = byte_q;
    left_d = left_q;
    if (load_i) begin
      byte_d = burst_i.bytes;
      left_d = burst_i.count;
    end else if (fire) begin
      byte_d = {8'h00, byte_q[sfe_pkg::BURST_MAX-1:1]};
      left_d = left_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 2'd0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((left_q == 2'd0) || ((left_q == 2'd1) && m_axis_tready)))
    else $error("burst loaded over unsent bytes");

  a_burst_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (burst_i.count != 2'd3 || burst_i.bytes[2] == sfe_pkg::LINE_END))
    else $error("three-byte burst must close with END");

  a_drain_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !load_i) |=> (left_q == $past(left_q) - 2'd1))
    else $error("burst count did not step down on send");

  a_empty_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && m_axis_tlast && !load_i) |=> !m_axis_tvalid)
    else $error("output still valid after last byte of item");

endmodule

### rtl/slip_frame_encoder_fcs16_top.sv
// Top level of the SLIP transmit framer with PPP FCS-16 trailer.
// Depends on sfe_pkg and sfe_burst_out.
//
// The output register sends the line bytes of each input item one per cycle
// while m_axis_tready is high: a plain payload byte causes one line byte, a
// start or an escaped payload byte two, an end one (no FCS) or three (with
// FCS), and an unused op code none. The FCS update and byte stuffing
// are done in the accept cycle, and the next item is taken in the same cycle
// the previous item's last byte is taken downstream. Type and FCS bytes are
// sent unescaped. Configuration writes are always ready.
module slip_frame_encoder_fcs16_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // checked_type_code
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] packet_type, [15:8] data_byte
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // line_byte
  output logic        m_axis_tlast    // last_of_run
);

  logic [7:0]      checked_type_q;
  logic [15:0]     fcs_q, fcs_d;
  logic            active_q, active_d;
  logic            s_fire;
  logic            space;
  logic [7:0]      pkt_type, data_byte;
  logic [15:0]     fcs_out;
  sfe_pkg::burst_t burst;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = space;
  assign s_fire        = s_axis_tvalid && space;
  assign pkt_type      = s_axis_tdata[7:0];
  assign data_byte     = s_axis_tdata[15:8];
  assign fcs_out       = ~fcs_q;

  always_comb begin
    fcs_d       = fcs_q;
    active_d    = active_q;
    burst.bytes = '0;
    burst.count = 2'd0;
    unique case (s_axis_tuser)
      sfe_pkg::OP_START: begin
        active_d       = (pkt_type == checked_type_q);
        fcs_d          = sfe_pkg::fcs_byte(sfe_pkg::FCS_INIT, pkt_type);
        burst.bytes[0] = sfe_pkg::LINE_END;
        burst.bytes[1] = pkt_type;
        burst.count    = 2'd2;
      end
      sfe_pkg::OP_DATA: begin
        if (active_q) begin
          fcs_d = sfe_pkg::fcs_byte(fcs_q, data_byte);
        end
        if (data_byte == sfe_pkg::LINE_END) begin
          burst.bytes[0] = sfe_pkg::LINE_ESC;
          burst.bytes[1] = sfe_pkg::LINE_ESC_END;
          burst.count    = 2'd2;
        end else if (data_byte == sfe_pkg::LINE_ESC) begin
          burst.bytes[0] = sfe_pkg::LINE_ESC;
          burst.bytes[1] = sfe_pkg::LINE_ESC_ESC;
          burst.count    = 2'd2;
        end else begin
          burst.bytes[0] = data_byte;
          burst.count    = 2'd1;
        end
      end
      sfe_pkg::OP_END: begin
        if (active_q) begin
          // complemented FCS, low byte first
          burst.bytes[0] = fcs_out[7:0];
          burst.bytes[1] = fcs_out[15:8];
          burst.bytes[2] = sfe_pkg::LINE_END;
          burst.count    = 2'd3;
        end else begin
          burst.bytes[0] = sfe_pkg::LINE_END;
          burst.count    = 2'd1;
        end
        active_d = 1'b0;
        fcs_d    = sfe_pkg::FCS_INIT;
      end
      default: begin
        // unused op: absorbed with no line bytes
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      checked_type_q <= sfe_pkg::CHECKED_TYPE_RST;
      fcs_q          <= sfe_pkg::FCS_INIT;
      active_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        checked_type_q <= cfg_data_i;
      end
      if (s_fire) begin
        fcs_q    <= fcs_d;
        active_q <= active_d;
      end
    end
  end

  sfe_burst_out u_burst_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s_fire),
    .burst_i       (burst),
    .space_o       (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_end_resets_fcs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser == sfe_pkg::OP_END) |=>
      (!active_q && fcs_q == sfe_pkg::FCS_INIT))
    else $error("end item did not clear FCS state");

  a_inactive_fcs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser == sfe_pkg::OP_DATA && !active_q) |=> $stable(fcs_q))
    else $error("FCS moved outside a checked packet");

  a_start_type_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser == sfe_pkg::OP_START && !cfg_valid_i) |=>
      (active_q == (checked_type_q == $past(s_axis_tdata[7:0]))))
    else $error("FCS enable does not follow packet type");

endmodule

### tb/slip_frame_encoder_fcs16_checker.sv
// Checker for the SLIP framer: watches the config, input and line channels,
// predicts the line bytes of each item and compares them in order.
// Depends on sfe_pkg for the line codes, FCS constants and op codes.
module slip_frame_encoder_fcs16_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last_of_run;
  } line_out_t;

  line_out_t   line_bytes_q[$];
  line_out_t   oldest;
  logic [7:0]  fcs_type_code;
  logic [15:0] fcs_acc;
  logic        fcs_on;
  int unsigned fails;

  // bitwise form of the reflected CRC: feed data LSB first
  function automatic logic [15:0] fcs16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ sfe_pkg::FCS_POLY;
    end
    return c;
  endfunction

  function automatic void queue_line_byte(input logic [7:0] b, input logic last);
    line_bytes_q.push_back('{line_byte: b, last_of_run: last});
  endfunction

  function automatic void encode_item(input logic [1:0] op, input logic [7:0] ptype,
                                      input logic [7:0] pbyte);
    logic [15:0] trailer;
    case (op)
      sfe_pkg::OP_START: begin
        fcs_on  = (ptype == fcs_type_code);
        fcs_acc = fcs16_update(sfe_pkg::FCS_INIT, ptype);
        queue_line_byte(sfe_pkg::LINE_END, 1'b0);
        queue_line_byte(ptype, 1'b1);
      end
      sfe_pkg::OP_DATA: begin
        if (fcs_on) fcs_acc = fcs16_update(fcs_acc, pbyte);
        if (pbyte == sfe_pkg::LINE_END) begin
          queue_line_byte(sfe_pkg::LINE_ESC, 1'b0);
          queue_line_byte(sfe_pkg::LINE_ESC_END, 1'b1);
        end else if (pbyte == sfe_pkg::LINE_ESC) begin
          queue_line_byte(sfe_pkg::LINE_ESC, 1'b0);
          queue_line_byte(sfe_pkg::LINE_ESC_ESC, 1'b1);
        end else begin
          queue_line_byte(pbyte, 1'b1);
        end
      end
      sfe_pkg::OP_END: begin
        if (fcs_on) begin
          trailer = fcs_acc ^ sfe_pkg::FCS_INIT;
          queue_line_byte(trailer[7:0], 1'b0);
          queue_line_byte(trailer[15:8], 1'b0);
        end
        queue_line_byte(sfe_pkg::LINE_END, 1'b1);
        fcs_on  = 1'b0;
        fcs_acc = sfe_pkg::FCS_INIT;
      end
      default: ;  // unused op: absorbed, no line bytes
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_type_code = sfe_pkg::CHECKED_TYPE_RST;
      fcs_acc       = sfe_pkg::FCS_INIT;
      fcs_on        = 1'b0;
      fails         = 0;
      line_bytes_q.delete();
    end else begin
      // line side first: an item taken at this edge cannot have a byte out yet
      if (m_tvalid_i && m_tready_i) begin
        if (line_bytes_q.size() == 0) begin
          $error("line byte %02h with nothing expected", m_tdata_i);
          fails++;
        end else begin
          oldest = line_bytes_q.pop_front();
          if (m_tdata_i !== oldest.line_byte) begin
            $error("line_byte: expected %02h, got %02h", oldest.line_byte, m_tdata_i);
            fails++;
          end
          if (m_tlast_i !== oldest.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", oldest.last_of_run, m_tlast_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) fcs_type_code = cfg_data_i;
      if (s_tvalid_i && s_tready_i) encode_item(s_tuser_i, s_tdata_i[7:0], s_tdata_i[15:8]);
    end
    fail_count_o <= fails;
    pending_o    <= line_bytes_q.size();
  end

endmodule

### tb/tb_slip_frame_encoder_fcs16_top.sv
// Testbench top for slip_frame_encoder_fcs16_top: drives framed packets,
// noise and config writes with random gaps and line stalls, gives the verdict.
// Depends on sfe_pkg, the DUT and slip_frame_encoder_fcs16_checker.
module tb_slip_frame_encoder_fcs16_top;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned PHASE_ITEMS = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = 16'h0000;  // [7:0] packet_type, [15:8] data_byte
  logic [1:0]  s_axis_tuser  = 2'd0;      // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;              // line_byte
  logic        m_axis_tlast;              // last_of_run

  int unsigned fail_count;
  int unsigned pending_bytes;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned sent_items  = 0;
  int unsigned phase_end;
  logic [7:0]  code_now;
  logic [7:0]  phase_codes[3];

  slip_frame_encoder_fcs16_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  slip_frame_encoder_fcs16_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending_bytes)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("slip_frame_encoder_fcs16_top verification failed");
      $finish;
    end
  end

  // line-side stall pattern: switches at random between four modes
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    if (cycle_count % 48 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= cycle_count[2];
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] ptype,
                           input logic [7:0] pbyte);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pbyte, ptype};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != OP_UNUSED) sent_items++;
  endtask

  // drop valid and wait until the checker reports every line byte out
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_checked_type(input logic [7:0] code);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    code_now = code;
  endtask

  // payload bytes biased toward the stuffed codes
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0:       return sfe_pkg::LINE_END;
      1:       return sfe_pkg::LINE_ESC;
      2:       return ($urandom_range(0, 1) != 0) ? sfe_pkg::LINE_ESC_END : sfe_pkg::LINE_ESC_ESC;
      3:       return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return code_now;
      6:                return ($urandom_range(0, 1) != 0) ? sfe_pkg::LINE_END : sfe_pkg::LINE_ESC;
      default:          return 8'($urandom());
    endcase
  endfunction

  task automatic random_frame;
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      send_item(sfe_pkg::OP_START, pick_type(), 8'($urandom()));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
      repeat (len) send_item(sfe_pkg::OP_DATA, 8'($urandom()), pick_payload());
      // kind 7 leaves the frame open; the next start restarts it
      if (kind != 7) send_item(sfe_pkg::OP_END, 8'($urandom()), 8'($urandom()));
    end else if (kind == 8) begin
      if ($urandom_range(0, 1) != 0) send_item(sfe_pkg::OP_DATA, 8'($urandom()), pick_payload());
      else send_item(sfe_pkg::OP_END, 8'($urandom()), 8'($urandom()));
    end else begin
      send_item(OP_UNUSED, 8'($urandom()), 8'($urandom()));
    end
  endtask

  initial begin
    code_now = sfe_pkg::CHECKED_TYPE_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // checked frame covering both stuffed codes and the ESC_END partner
    send_item(sfe_pkg::OP_START, 8'hA9, 8'h00);
    send_item(sfe_pkg::OP_DATA,  8'h00, 8'h00);
    send_item(sfe_pkg::OP_DATA,  8'hFF, 8'hFF);
    send_item(sfe_pkg::OP_DATA,  8'h00, sfe_pkg::LINE_END);
    send_item(sfe_pkg::OP_DATA,  8'h00, sfe_pkg::LINE_ESC);
    send_item(sfe_pkg::OP_DATA,  8'h00, sfe_pkg::LINE_ESC_END);
    send_item(sfe_pkg::OP_END,   8'h00, 8'h00);
    // type bytes equal to END and ESC go out raw
    send_item(sfe_pkg::OP_START, sfe_pkg::LINE_END, 8'hFF);
    send_item(sfe_pkg::OP_DATA,  8'h00, sfe_pkg::LINE_ESC_ESC);
    send_item(sfe_pkg::OP_END,   8'h00, 8'h00);
    send_item(sfe_pkg::OP_START, sfe_pkg::LINE_ESC, 8'h00);
    send_item(sfe_pkg::OP_END,   8'h00, 8'h00);
    // payload and end outside any frame
    send_item(sfe_pkg::OP_DATA,  8'h00, 8'h55);
    send_item(sfe_pkg::OP_END,   8'hFF, 8'hFF);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
    // restart inside an open frame, checked to unchecked and back
    send_item(sfe_pkg::OP_START, 8'hA9, 8'h00);
    send_item(sfe_pkg::OP_DATA,  8'h00, 8'h12);
    send_item(sfe_pkg::OP_START, 8'hFF, 8'h00);
    send_item(sfe_pkg::OP_END,   8'h00, 8'h00);
    send_item(sfe_pkg::OP_START, 8'h00, 8'h00);
    send_item(sfe_pkg::OP_START, 8'hA9, 8'h00);
    send_item(sfe_pkg::OP_DATA,  8'h00, 8'h80);
    send_item(sfe_pkg::OP_END,   8'h00, 8'h00);

    phase_codes[0] = 8'h00;
    phase_codes[1] = 8'hFF;
    phase_codes[2] = 8'($urandom_range(1, 254));
    phase_end = sent_items + PHASE_ITEMS;
    while (sent_items < phase_end) random_frame();
    foreach (phase_codes[i]) begin
      drain();
      write_checked_type(phase_codes[i]);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) random_frame();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("slip_frame_encoder_fcs16_top verification clean");
    end else begin
      $display("slip_frame_encoder_fcs16_top verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/sfe_pkg.sv
rtl/sfe_burst_out.sv
rtl/slip_frame_encoder_fcs16_top.sv
tb/slip_frame_encoder_fcs16_checker.sv
tb/tb_slip_frame_encoder_fcs16_top.sv
